// ===== design/vcf_pkg.sv =====
// Package for the vertical complementary filter core.
// Holds sizes, register indexes, reset values and the fixed-point helpers.
// No dependencies.
`default_nettype none
package vcf_pkg;
   localparam int HISTORY_DEPTH   = 15;
   localparam int STARTUP_SAMPLES = 11;
   localparam int HEAD_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int START_W = $clog2(STARTUP_SAMPLES + 1);

   localparam int Q_W   = 48;
   localparam int IN_W  = 32;
   localparam int CFG_W = 16;
   localparam int IDX_W = 2;

   typedef logic signed [Q_W-1:0] q48_type;

   localparam logic [IDX_W-1:0] REG_TIME_STEP     = 2'd0;
   localparam logic [IDX_W-1:0] REG_POSITION_GAIN = 2'd1;
   localparam logic [IDX_W-1:0] REG_VELOCITY_GAIN = 2'd2;
   localparam logic [IDX_W-1:0] REG_ACCEL_GAIN    = 2'd3;

   localparam logic [CFG_W-1:0] RST_TIME_STEP     = 16'd655;
   localparam logic [CFG_W-1:0] RST_POSITION_GAIN = 16'd39322;
   localparam logic [CFG_W-1:0] RST_VELOCITY_GAIN = 16'd7864;
   localparam logic [CFG_W-1:0] RST_ACCEL_GAIN    = 16'd524;

   localparam q48_type Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam q48_type Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

   // clamp a 49-bit sum to the signed 48-bit range
   function automatic q48_type sat48(input logic signed [Q_W:0] s);
      q48_type r;
      if (s > $signed({Q_MAX[Q_W-1], Q_MAX})) r = Q_MAX;
      else if (s < $signed({Q_MIN[Q_W-1], Q_MIN})) r = Q_MIN;
      else r = s[Q_W-1:0];
      return r;
   endfunction

   function automatic q48_type add_sat(input q48_type a, input q48_type b);
      logic signed [Q_W:0] s;
      s = {a[Q_W-1], a} + {b[Q_W-1], b};
      return sat48(s);
   endfunction

   // floor(a * g / 2^16), g unsigned Q0.16
   function automatic q48_type mulq(input q48_type a, input logic [CFG_W-1:0] g);
      logic signed [64:0] p;
      p = $signed({{17{a[Q_W-1]}}, a}) * $signed({49'd0, g});
      return p[63:16];
   endfunction
endpackage
`default_nettype wire

// ===== design/vertical_complementary_filter_core.sv =====
// Vertical complementary filter core: third-order altitude and velocity estimator.
// Each accepted req word yields one rsp word, later if rsp is stalled; a new sample
// is taken only after the last one is done: one shared 48x16 multiplier is stepped
// through eight operations by the sequencer, and req_tready is low meanwhile.
// Reset (synchronous, active high) restores the default gains and clears the
// filter state (not the history buffer), the start-up count and the history fill count.
`default_nettype none
module vertical_complementary_filter_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [63:0]   req_tdata,   // baro_altitude[31:0], vertical_accel[63:32]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [143:0]       rsp_tdata,   // position_estimate[47:0], velocity_estimate[95:48],
                                           // position_error[143:96]
   input  wire logic          csr_we,
   input  wire logic [vcf_pkg::IDX_W-1:0] csr_index,
   input  wire logic [vcf_pkg::CFG_W-1:0] csr_wdata
);
   import vcf_pkg::*;

   // sequencer codes
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LOAD = 4'd1;  // start-up force, delayed + correction
   localparam logic [3:0] S_ERR  = 4'd2;  // error against barometer
   localparam logic [3:0] S_K3   = 4'd3;
   localparam logic [3:0] S_AC   = 4'd4;
   localparam logic [3:0] S_K2   = 4'd5;
   localparam logic [3:0] S_V    = 4'd6;
   localparam logic [3:0] S_K1   = 4'd7;
   localparam logic [3:0] S_PC   = 4'd8;
   localparam logic [3:0] S_SUMA = 4'd9;  // acc + accel correction
   localparam logic [3:0] S_VINC = 4'd10;
   localparam logic [3:0] S_HALF = 4'd11; // velocity + vinc/2
   localparam logic [3:0] S_BASE = 4'd12;
   localparam logic [3:0] S_OUT  = 4'd13;

   logic [3:0] state_ff, state_in;

   // configuration
   logic [CFG_W-1:0] dt_ff, k1_ff, k2_ff, k3_ff;

   // filter state
   q48_type ac_ff, ac_in, vel_ff, vel_in, base_ff, base_in, pc_ff, pc_in;
   logic [START_W-1:0] start_ff, start_in;
   q48_type hist_ff [HISTORY_DEPTH];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [HEAD_W-1:0] head_ff, head_in;

   // working registers
   q48_type baro_ff, baro_in, acc_ff, acc_in, err_ff, err_in;
   q48_type tmp_ff, tmp_in, vinc_ff, vinc_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   q48_type pos_out_ff, pos_out_in, vel_out_ff, vel_out_in, err_out_ff, err_out_in;

   // shared multiplier
   q48_type          mul_a, mul_q;
   logic [CFG_W-1:0] mul_g;

   q48_type baro_ext, acc_ext, base_eff, pc_eff, delayed;
   logic    push;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {err_out_ff, vel_out_ff, pos_out_ff};

   // sign-extend the fields; on accept they are scaled metres to centimetres: x*100 = x*64 + x*32 + x*4
   assign baro_ext = Q_W'($signed(req_tdata[IN_W-1:0]));
   assign acc_ext  = Q_W'($signed(req_tdata[2*IN_W-1:IN_W]));

   // start-up force applies before the error is taken
   assign base_eff = (start_ff < START_W'(STARTUP_SAMPLES)) ? baro_ff : base_ff;
   assign pc_eff   = (start_ff < START_W'(STARTUP_SAMPLES)) ? '0 : pc_ff;
   assign delayed  = (fill_ff >= FILL_W'(HISTORY_DEPTH)) ? hist_ff[head_ff] : base_eff;

   // select multiplier operands by step
   always_comb begin
      mul_a = tmp_ff;
      mul_g = dt_ff;
      unique case (state_ff)
         S_K3: begin mul_a = err_ff; mul_g = k3_ff; end
         S_K2: begin mul_a = err_ff; mul_g = k2_ff; end
         S_K1: begin mul_a = err_ff; mul_g = k1_ff; end
         default: begin mul_a = tmp_ff; mul_g = dt_ff; end
      endcase
      mul_q = mulq(mul_a, mul_g);
   end

   always_comb begin
      state_in     = state_ff;
      ac_in        = ac_ff;
      vel_in       = vel_ff;
      base_in      = base_ff;
      pc_in        = pc_ff;
      start_in     = start_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      baro_in      = baro_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      tmp_in       = tmp_ff;
      vinc_in      = vinc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pos_out_in   = pos_out_ff;
      vel_out_in   = vel_out_ff;
      err_out_in   = err_out_ff;
      push         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               baro_in  = (baro_ext <<< 6) + (baro_ext <<< 5) + (baro_ext <<< 2);
               acc_in   = (acc_ext <<< 6) + (acc_ext <<< 5) + (acc_ext <<< 2);
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            base_in = base_eff;
            pc_in   = pc_eff;
            if (start_ff < START_W'(STARTUP_SAMPLES)) start_in = start_ff + 1'b1;
            tmp_in   = add_sat(delayed, pc_eff);
            state_in = S_ERR;
         end
         S_ERR: begin
            err_in   = sat48({baro_ff[Q_W-1], baro_ff} - {tmp_ff[Q_W-1], tmp_ff});
            state_in = S_K3;
         end
         S_K3: begin tmp_in = mul_q; state_in = S_AC; end
         S_AC: begin ac_in = add_sat(ac_ff, mul_q); state_in = S_K2; end
         S_K2: begin tmp_in = mul_q; state_in = S_V; end
         S_V:  begin vel_in = add_sat(vel_ff, mul_q); state_in = S_K1; end
         S_K1: begin tmp_in = mul_q; state_in = S_PC; end
         S_PC: begin pc_in = add_sat(pc_ff, mul_q); state_in = S_SUMA; end
         S_SUMA: begin tmp_in = add_sat(acc_ff, ac_ff); state_in = S_VINC; end
         S_VINC: begin vinc_in = mul_q; state_in = S_HALF; end
         S_HALF: begin tmp_in = add_sat(vel_ff, vinc_ff >>> 1); state_in = S_BASE; end
         S_BASE: begin base_in = add_sat(base_ff, mul_q); state_in = S_OUT; end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               push         = 1'b1;
               vel_in       = add_sat(vel_ff, vinc_ff);
               pos_out_in   = add_sat(base_ff, pc_ff);
               vel_out_in   = add_sat(vel_ff, vinc_ff);
               err_out_in   = err_ff;
               rsp_valid_in = 1'b1;
               head_in = (head_ff == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               if (fill_ff < FILL_W'(HISTORY_DEPTH)) fill_in = fill_ff + 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dt_ff        <= RST_TIME_STEP;
         k1_ff        <= RST_POSITION_GAIN;
         k2_ff        <= RST_VELOCITY_GAIN;
         k3_ff        <= RST_ACCEL_GAIN;
         ac_ff        <= '0;
         vel_ff       <= '0;
         base_ff      <= '0;
         pc_ff        <= '0;
         start_ff     <= '0;
         fill_ff      <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ac_ff        <= ac_in;
         vel_ff       <= vel_in;
         base_ff      <= base_in;
         pc_ff        <= pc_in;
         start_ff     <= start_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_TIME_STEP:     dt_ff <= csr_wdata;
               REG_POSITION_GAIN: k1_ff <= csr_wdata;
               REG_VELOCITY_GAIN: k2_ff <= csr_wdata;
               REG_ACCEL_GAIN:    k3_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      baro_ff    <= baro_in;
      acc_ff     <= acc_in;
      err_ff     <= err_in;
      tmp_ff     <= tmp_in;
      vinc_ff    <= vinc_in;
      pos_out_ff <= pos_out_in;
      vel_out_ff <= vel_out_in;
      err_out_ff <= err_out_in;
      if (push) hist_ff[head_ff] <= base_ff;
   end
endmodule
`default_nettype wire

// ===== design/vcf_checker.sv =====
// Port-level checker for the vertical complementary filter core.
// Depends on vertical_complementary_filter_core; bound to it below.
`default_nettype none
module vcf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready
);
   // a stalled word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("rsp word dropped");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid) else $error("rsp valid after reset");

   // busy while a sample is being worked
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready while busy");

   // no result appears the cycle after a sample is taken
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid)) else $error("early result");
endmodule

bind vertical_complementary_filter_core vcf_checker u_vcf_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready)
);
`default_nettype wire

// ===== tb/vertical_complementary_filter_core_tb.sv =====
// Self-checking bench for the vertical complementary filter core.
// Drives barometer/accelerometer words, predicts each estimate word and compares.
// Depends on vcf_pkg and vertical_complementary_filter_core.
`default_nettype none

class vcf_scoreboard;
   typedef struct packed {
      logic signed [47:0] pos;
      logic signed [47:0] vel;
      logic signed [47:0] err;
   } estimate_type;

   logic [15:0] dt, k1, k2, k3;
   longint ac, v, base, pc;
   int startup_count, fill, head;
   longint hist [15];
   estimate_type pending [$];
   int errors;

   function new();
      errors = 0;
      dt = vcf_pkg::RST_TIME_STEP;
      k1 = vcf_pkg::RST_POSITION_GAIN;
      k2 = vcf_pkg::RST_VELOCITY_GAIN;
      k3 = vcf_pkg::RST_ACCEL_GAIN;
      ac = 0; v = 0; base = 0; pc = 0;
      startup_count = 0; fill = 0; head = 0;
   endfunction

   function longint clamp(longint x);
      longint hi, lo;
      hi = 64'sh7FFF_FFFF_FFFF;
      lo = -64'sh8000_0000_0000;
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   // floor(a*g/65536); a is 48 bits so the product fits in 64
   function longint scale(longint a, logic [15:0] g);
      longint p;
      p = a * longint'({48'd0, g});
      return p >>> 16;
   endfunction

   function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
         vcf_pkg::REG_TIME_STEP:     dt = val;
         vcf_pkg::REG_POSITION_GAIN: k1 = val;
         vcf_pkg::REG_VELOCITY_GAIN: k2 = val;
         vcf_pkg::REG_ACCEL_GAIN:    k3 = val;
         default: ;
      endcase
   endfunction

   function void note_sample(logic [31:0] baro_in, logic [31:0] acc_in);
      longint baro, acc, delayed, e, vinc, pos;
      estimate_type r;
      baro = longint'($signed(baro_in)) * 100;
      acc = longint'($signed(acc_in)) * 100;
      if (startup_count < vcf_pkg::STARTUP_SAMPLES) begin
         base = baro;
         pc = 0;
         startup_count++;
      end
      delayed = (fill >= 15) ? hist[head] : base;
      e = clamp(baro - clamp(delayed + pc));
      ac = clamp(ac + scale(scale(e, k3), dt));
      v = clamp(v + scale(scale(e, k2), dt));
      pc = clamp(pc + scale(scale(e, k1), dt));
      vinc = scale(clamp(acc + ac), dt);
      base = clamp(base + scale(clamp(v + scale(vinc, 16'd32768)), dt));
      pos = clamp(base + pc);
      v = clamp(v + vinc);
      hist[head] = base;
      head = (head + 1 >= 15) ? 0 : head + 1;
      if (fill < 15) fill++;
      r.pos = pos[47:0];
      r.vel = v[47:0];
      r.err = e[47:0];
      pending.push_back(r);
   endfunction

   function void check_estimate(logic [143:0] word);
      estimate_type exp_r;
      if (pending.size() == 0) begin
         $error("unexpected rsp word %h", word);
         errors++;
         return;
      end
      exp_r = pending.pop_front();
      if (word[47:0] !== exp_r.pos) begin
         $error("position_estimate expected %h actual %h", exp_r.pos, word[47:0]);
         errors++;
      end
      if (word[95:48] !== exp_r.vel) begin
         $error("velocity_estimate expected %h actual %h", exp_r.vel, word[95:48]);
         errors++;
      end
      if (word[143:96] !== exp_r.err) begin
         $error("position_error expected %h actual %h", exp_r.err, word[143:96]);
         errors++;
      end
   endfunction
endclass

module vertical_complementary_filter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;     // baro_altitude[31:0], vertical_accel[63:32]
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;         // position_estimate, velocity_estimate, position_error
   logic csr_we = 1'b0;
   logic [vcf_pkg::IDX_W-1:0] csr_index = '0;
   logic [vcf_pkg::CFG_W-1:0] csr_wdata = '0;

   vcf_scoreboard estimates = new();
   bit idling_on = 1'b1;

   vertical_complementary_filter_core u_top (.*);

   always #1 clock = ~clock;

   // hard stop well beyond the slowest legal run
   initial begin
      #4ms;
      $display("== FAIL ==");
      $finish;
   end

   // result side: random stall bursts, check every accepted word at the rising edge
   initial begin
      int stall;
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 15);
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) estimates.check_estimate(rsp_tdata);

   // send one sample word; hold until accepted, drop valid at the next falling edge
   task automatic send_sample(logic [31:0] baro, logic [31:0] acc);
      int gap;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         repeat (gap) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {acc, baro};
      do @(posedge clock); while (!req_tready);
      estimates.note_sample(baro, acc);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // write a register while the block is idle
   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      estimates.write_reg(idx, val);
   endtask

   task automatic drain();
      while (estimates.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // plausible sensor values, with occasional full-range words
   function automatic logic [31:0] pick(int span);
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(0, 2 * span) - span;
   endfunction

   initial begin
      logic [15:0] cfg [4];
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, start-up, history fill, saturation
      send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
      send_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
      send_sample(32'h0, 32'h0);
      send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < 16; i++) send_sample(32'h0001_0000 * i, 32'h0000_8000);
      drain();

      // directed: zero time step, then maximum gains
      write_csr(vcf_pkg::REG_TIME_STEP, 16'd0);
      send_sample(32'h0010_0000, 32'h0001_0000);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000);
      drain();
      write_csr(vcf_pkg::REG_TIME_STEP, 16'hFFFF);
      write_csr(vcf_pkg::REG_POSITION_GAIN, 16'hFFFF);
      write_csr(vcf_pkg::REG_VELOCITY_GAIN, 16'hFFFF);
      write_csr(vcf_pkg::REG_ACCEL_GAIN, 16'hFFFF);
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_sample(32'h8000_0000, 32'h8000_0000);
      drain();

      // random phases with varied settings; the last phase runs without idling
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: cfg = '{vcf_pkg::RST_TIME_STEP, vcf_pkg::RST_POSITION_GAIN,
                       vcf_pkg::RST_VELOCITY_GAIN, vcf_pkg::RST_ACCEL_GAIN};
            1: cfg = '{16'd1, 16'd0, 16'd0, 16'd0};
            2: cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            default: cfg = '{16'($urandom_range(1, 65535)), 16'($urandom),
                             16'($urandom), 16'($urandom)};
         endcase
         if (ph == 5) idling_on = 1'b0;
         for (int r = 0; r < 4; r++) write_csr(r[1:0], cfg[r]);
         for (int n = 0; n < 300; n++)
            send_sample(pick(32'h0100_0000), pick(32'h0020_0000));
         drain();
      end

      if (estimates.errors == 0 && estimates.pending.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

// ===== files.f =====
design/vcf_pkg.sv
design/vertical_complementary_filter_core.sv
design/vcf_checker.sv
tb/vertical_complementary_filter_core_tb.sv
